// ===== hw/rtl/led_serial_driver_update_sequencer_assert.svh =====
// Assertion macros used by the checker of the LED update sequencer.
`ifndef LED_SERIAL_DRIVER_UPDATE_SEQUENCER_ASSERT_SVH
`define LED_SERIAL_DRIVER_UPDATE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LSDUS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LSDUS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lsdus_pkg.sv =====
package lsdus_pkg;

  // Drivers in the chain
  localparam int DRIVER_COUNT = 2;
  localparam int DRV_IDX_W    = (DRIVER_COUNT > 1) ? $clog2(DRIVER_COUNT) : 1;

  // Byte counter over one update: driver index plus nibble select
  localparam int BYTE_CNT_W   = DRV_IDX_W + 1;

  // Acknowledge bits that belong to the chain
  localparam logic [7:0] ALL_MASK = 8'((16'd1 << DRIVER_COUNT) - 16'd1);

  // Reset value of the hold register and counter
  localparam logic [15:0] HOLD_RESET = 16'd10;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_DONE  = 2'd1,
    REQ_ACK   = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_RESET_WAIT = 2'd0,
    PH_IDLE       = 2'd1,
    PH_SENDING    = 2'd2,
    PH_CHECKING   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_EMIT   = 2'd2,
    ST_STATUS = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] driver_index;
    logic [7:0] led_byte;
    logic [7:0] ack_low_mask;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       byte_valid;
    logic       last_result;
    logic       reset_active;
    logic [1:0] phase;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic emit_byte;
    logic emit_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic will_start;
    logic last_byte;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/lsdus_ctrl.sv =====
module lsdus_ctrl
  import lsdus_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = status.will_start ? ST_EMIT : ST_STATUS;
      end
      ST_EMIT: begin
        if (status.slot_free && status.last_byte) state_next = ST_IDLE;
      end
      ST_STATUS: begin
        if (status.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready         = (state == ST_IDLE);
    cmd.load         = (state == ST_IDLE) && in_valid;
    cmd.exec         = (state == ST_EXEC);
    cmd.emit_byte    = (state == ST_EMIT) && status.slot_free;
    cmd.emit_status  = (state == ST_STATUS) && status.slot_free;
  end

endmodule

// ===== hw/rtl/lsdus_dp.sv =====
module lsdus_dp
  import lsdus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  dp_cmd_t     cmd,
  output dp_status_t  status
);

  in_item_t              item;
  logic [15:0]           hold_ticks;
  phase_t                phase_reg;
  logic [15:0]           hold_counter;
  logic [7:0]            ack_bits;
  logic                  update_pending;
  logic [7:0]            led_store [DRIVER_COUNT];
  logic                  reset_line;
  logic [BYTE_CNT_W-1:0] byte_cnt;

  logic                  idx_ok;
  logic [DRV_IDX_W-1:0]  tx_idx;
  logic                  tx_high;
  logic [7:0]            tx_led;
  logic [2:0]            tx_addr;
  logic [7:0]            tx_byte;

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_we) begin
      hold_ticks <= cfg_wdata;
    end
  end

  assign idx_ok = (32'(item.driver_index) < DRIVER_COUNT);

  // Tick that kicks off a transmission
  assign status.will_start = (item.req_type == REQ_TICK) &&
                             ((phase_reg == PH_RESET_WAIT && hold_counter <= 16'd1) ||
                              (phase_reg == PH_IDLE && update_pending));

  // Sequencer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_RESET_WAIT;
      hold_counter   <= HOLD_RESET;
      ack_bits       <= '0;
      update_pending <= 1'b0;
      reset_line     <= 1'b1;
      byte_cnt       <= '0;
      for (int i = 0; i < DRIVER_COUNT; i++) led_store[i] <= '0;
    end else begin
      if (cmd.exec) begin
        unique case (req_t'(item.req_type))
          REQ_WRITE: begin
            if (idx_ok) begin
              led_store[item.driver_index[DRV_IDX_W-1:0]] <= item.led_byte;
              update_pending <= 1'b1;
            end
          end
          REQ_DONE: begin
            if (phase_reg == PH_SENDING) phase_reg <= PH_CHECKING;
          end
          REQ_ACK: begin
            ack_bits <= ack_bits | (item.ack_low_mask & ALL_MASK);
          end
          REQ_TICK: begin
            unique case (phase_reg)
              PH_CHECKING: begin
                if (ack_bits == ALL_MASK) begin
                  ack_bits  <= '0;
                  phase_reg <= PH_IDLE;
                end else begin
                  reset_line   <= 1'b1;
                  phase_reg    <= PH_RESET_WAIT;
                  hold_counter <= hold_ticks;
                end
              end
              PH_RESET_WAIT: begin
                if (hold_counter <= 16'd1) begin
                  hold_counter <= '0;
                  reset_line   <= 1'b0;
                end else begin
                  hold_counter <= hold_counter - 16'd1;
                end
              end
              PH_IDLE, PH_SENDING: begin
              end
              default: begin
              end
            endcase
            if (status.will_start) begin
              update_pending <= 1'b0;
              ack_bits       <= '0;
              phase_reg      <= PH_SENDING;
              byte_cnt       <= '0;
            end
          end
          default: begin
          end
        endcase
      end else if (cmd.emit_byte) begin
        byte_cnt <= byte_cnt + BYTE_CNT_W'(1);
      end
    end
  end

  // Framed byte: LED nibble in the top half, address and start bit below
  assign tx_idx  = byte_cnt[BYTE_CNT_W-1:1];
  assign tx_high = byte_cnt[0];
  assign tx_led  = led_store[tx_idx];
  assign tx_addr = 3'(tx_idx);
  assign tx_byte = tx_high ? {tx_led[7:4], tx_addr, 1'b1} : {tx_led[3:0], tx_addr, 1'b1};

  assign status.last_byte = tx_high && (32'(tx_idx) == DRIVER_COUNT - 1);
  assign status.slot_free = !out_valid || out_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_data.tx_byte      <= tx_byte;
      out_data.byte_valid   <= 1'b1;
      out_data.last_result  <= status.last_byte;
      out_data.reset_active <= reset_line;
      out_data.phase        <= phase_reg;
    end else if (cmd.emit_status) begin
      out_data.tx_byte      <= '0;
      out_data.byte_valid   <= 1'b0;
      out_data.last_result  <= 1'b1;
      out_data.reset_active <= reset_line;
      out_data.phase        <= phase_reg;
    end
  end

endmodule

// ===== hw/rtl/led_serial_driver_update_sequencer.sv =====
// An accepted item is latched, executed in the EXEC state, then its result is
// registered into the output from the EMIT or STATUS state; one item at a time.
// A status item gives one status beat, an update tick 2*DRIVER_COUNT byte beats,
// one byte per cycle from the emit sequencer while the output is not stalled.
// Reset (rst, synchronous): reset wait phase, driver reset line asserted,
// hold register and counter at 10, LED bytes, acks and pending flag cleared.
module led_serial_driver_update_sequencer
  import lsdus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lsdus_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lsdus_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== hw/rtl/lsdus_chk.sv =====
`include "led_serial_driver_update_sequencer_assert.svh"

module lsdus_chk
  import lsdus_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Stalled result beat holds
  `LSDUS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // Byte beats only go out while sending with the driver reset released
  `LSDUS_ASSERT_NOW(a_byte_phase, clk, rst, out_valid && out_data.byte_valid, !out_data.reset_active && out_data.phase == PH_SENDING, "byte beat outside sending phase")

  // Status beats are single and empty
  `LSDUS_ASSERT_NOW(a_status_beat, clk, rst, out_valid && !out_data.byte_valid, out_data.last_result && out_data.tx_byte == 8'd0, "status beat not last or not empty")

  // One item in flight at a time
  `LSDUS_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "input taken while an item is in flight")

endmodule

bind led_serial_driver_update_sequencer lsdus_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/testbench.sv =====
package led_frame_check_pkg;
  import lsdus_pkg::*;

  // Scoreboard: tracks the sequencer state and the frames it should emit
  class led_frame_scoreboard;
    // Mirrored sequencer state
    phase_t      ph;
    logic [15:0] hold_cfg;
    logic [15:0] hold_cnt;
    logic [7:0]  acks;
    bit          pending;
    logic [7:0]  leds [DRIVER_COUNT];
    bit          line;

    out_item_t   expected_frames [$];
    int          mismatches;
    int          n_requests;
    int          n_updates;
    int          n_retries;
    int          n_bytes;
    int          n_beats;

    function new();
      ph       = PH_RESET_WAIT;
      hold_cfg = HOLD_RESET;
      hold_cnt = HOLD_RESET;
      acks     = '0;
      pending  = 0;
      line     = 1;
      foreach (leds[i]) leds[i] = '0;
    endfunction

    function void set_hold(logic [15:0] ticks);
      hold_cfg = ticks;
    endfunction

    function int outstanding();
      return expected_frames.size();
    endfunction

    function void push_frame(logic [7:0] b, logic v, logic last);
      out_item_t f;
      f.tx_byte      = b;
      f.byte_valid   = v;
      f.last_result  = last;
      f.reset_active = line;
      f.phase        = ph;
      expected_frames.push_back(f);
    endfunction

    // Two frames per driver, driver 0 first, low nibble first
    function void start_frames();
      logic [7:0] addr;
      pending = 0;
      acks    = '0;
      ph      = PH_SENDING;
      n_updates++;
      for (int i = 0; i < DRIVER_COUNT; i++) begin
        addr = 8'((i << 1) | 1);
        push_frame({leds[i][3:0], 4'h0} | addr, 1'b1, 1'b0);
        push_frame((leds[i] & 8'hF0) | addr, 1'b1, 1'(i == DRIVER_COUNT - 1));
      end
    endfunction

    // Called on every accepted input beat
    function void note_request(in_item_t req);
      req_t kind;
      kind = req_t'(req.req_type);
      n_requests++;
      case (kind)
        REQ_WRITE: begin
          // writes beyond the chain are dropped
          if (req.driver_index < DRIVER_COUNT) begin
            leds[req.driver_index] = req.led_byte;
            pending = 1;
          end
        end
        REQ_DONE: begin
          if (ph == PH_SENDING) ph = PH_CHECKING;
        end
        REQ_ACK: begin
          acks = acks | (req.ack_low_mask & ALL_MASK);
        end
        default: begin
          case (ph)
            PH_CHECKING: begin
              if (acks == ALL_MASK) begin
                acks = '0;
                ph   = PH_IDLE;
              end else begin
                line     = 1;
                ph       = PH_RESET_WAIT;
                hold_cnt = hold_cfg;
                n_retries++;
              end
            end
            PH_RESET_WAIT: begin
              // a hold of 0 or 1 expires on this tick
              if (hold_cnt <= 16'd1) begin
                hold_cnt = '0;
                line     = 0;
                start_frames();
                return;
              end
              hold_cnt = hold_cnt - 16'd1;
            end
            PH_IDLE: begin
              if (pending) begin
                start_frames();
                return;
              end
            end
            default: ;
          endcase
        end
      endcase
      push_frame(8'h00, 1'b0, 1'b1);
    endfunction

    function void note_mismatch(string why, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected tx=%02h vld=%b last=%b rst=%b ph=%0d, got tx=%02h vld=%b last=%b rst=%b ph=%0d",
                 why, want.tx_byte, want.byte_valid, want.last_result, want.reset_active,
                 want.phase, got.tx_byte, got.byte_valid, got.last_result,
                 got.reset_active, got.phase);
    endfunction

    // Called on every accepted output beat
    function void check_frame(out_item_t got);
      out_item_t want;
      n_beats++;
      if (got.byte_valid === 1'b1) n_bytes++;
      if (expected_frames.size() == 0) begin
        note_mismatch("unexpected beat", '0, got);
        return;
      end
      want = expected_frames.pop_front();
      if (got.tx_byte !== want.tx_byte || got.byte_valid !== want.byte_valid ||
          got.last_result !== want.last_result ||
          got.reset_active !== want.reset_active || got.phase !== want.phase)
        note_mismatch("beat mismatch", want, got);
    endfunction
  endclass

endpackage

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsdus_pkg::*;
  import led_frame_check_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_PAD   = 6;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  led_frame_scoreboard sb;
  bit          stalls_on;
  int          stall_cycles;
  int          hold_run_ticks;

  led_serial_driver_update_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Output side: random backpressure bursts
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_frame(out_data);
  end

  // Watchdog: no beat moving on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("led_serial_driver_update_sequencer: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t make_req(req_t kind, logic [2:0] idx, logic [7:0] led,
                                        logic [7:0] ack);
    in_item_t r;
    r.req_type     = kind;
    r.driver_index = idx;
    r.led_byte     = led;
    r.ack_low_mask = ack;
    return r;
  endfunction

  // Mostly well-formed traffic steered by the predicted phase, some noise
  function automatic in_item_t pick_request();
    in_item_t r;
    r.req_type     = 2'($urandom_range(0, 3));
    r.driver_index = 3'($urandom_range(0, 7));
    r.led_byte     = 8'($urandom_range(0, 255));
    r.ack_low_mask = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 12) return r;
    if ($urandom_range(0, 99) < 85) r.driver_index = 3'($urandom_range(0, DRIVER_COUNT - 1));
    case (sb.ph)
      PH_IDLE: begin
        r.req_type = (!sb.pending || $urandom_range(0, 3) == 0) ? REQ_WRITE : REQ_TICK;
      end
      PH_SENDING: begin
        if (sb.acks != ALL_MASK && $urandom_range(0, 2) != 0) begin
          r.req_type = REQ_ACK;
          if ($urandom_range(0, 2) != 0) r.ack_low_mask = r.ack_low_mask | ALL_MASK;
        end else begin
          r.req_type = REQ_DONE;
        end
      end
      PH_CHECKING: r.req_type = ($urandom_range(0, 5) == 0) ? REQ_ACK : REQ_TICK;
      default:     r.req_type = ($urandom_range(0, 5) == 0) ? REQ_WRITE : REQ_TICK;
    endcase
    return r;
  endfunction

  task automatic send_item(input in_item_t item);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_request(item);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(pick_request());
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic program_hold(input logic [15:0] ticks);
    pause_until_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    sb.set_hold(ticks);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    in_item_t r;
    sb = new();
    stalls_on = 0;
    hold_run_ticks = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: hold of 1, counter still at its reset value
    program_hold(16'd1);
    stalls_on = 1;
    send_item(make_req(REQ_WRITE, 3'd0, 8'hFF, 8'h00));
    send_item(make_req(REQ_WRITE, 3'd1, 8'h00, 8'hFF));
    send_item(make_req(REQ_WRITE, 3'd7, 8'hA5, 8'h00));  // beyond the chain
    send_item(make_req(REQ_DONE,  3'd0, 8'h00, 8'h00));  // done while in reset wait
    send_item(make_req(REQ_ACK,   3'd0, 8'h00, 8'hFF));  // upper ack bits dropped
    repeat (10) send_item(make_req(REQ_TICK, 3'd0, 8'h00, 8'h00));
    send_item(make_req(REQ_TICK,  3'd0, 8'h00, 8'h00));  // tick while sending
    send_item(make_req(REQ_ACK,   3'd0, 8'h00, 8'h01));
    send_item(make_req(REQ_DONE,  3'd0, 8'h00, 8'h00));
    send_item(make_req(REQ_TICK,  3'd0, 8'h00, 8'h00));  // partial acks: retry
    send_item(make_req(REQ_WRITE, 3'd1, 8'h3C, 8'h00));  // request while busy
    send_item(make_req(REQ_TICK,  3'd0, 8'h00, 8'h00));
    send_item(make_req(REQ_ACK,   3'd0, 8'h00, 8'h03));
    send_item(make_req(REQ_DONE,  3'd0, 8'h00, 8'h00));
    send_item(make_req(REQ_TICK,  3'd0, 8'h00, 8'h00));  // all acked: idle
    send_item(make_req(REQ_TICK,  3'd0, 8'h00, 8'h00));  // idle, nothing pending
    send_item(make_req(REQ_DONE,  3'd0, 8'h00, 8'h00));  // done while idle
    send_item(make_req(REQ_WRITE, 3'd0, 8'h5A, 8'h00));
    send_item(make_req(REQ_TICK,  3'd0, 8'h00, 8'h00));  // update from idle

    // Hold of zero: expires on the first tick
    program_hold(16'd0);
    send_random(100);

    // Long hold: run one retry through the full count without stalls
    program_hold(16'd40);
    while (!(sb.ph == PH_RESET_WAIT && sb.hold_cnt == 16'd40)) send_item(pick_request());
    stalls_on = 0;
    while (sb.ph == PH_RESET_WAIT) begin
      r = pick_request();
      r.req_type = REQ_TICK;
      send_item(r);
      hold_run_ticks++;
    end
    stalls_on = 1;

    // Mid-range hold with a full drain in the middle
    program_hold(16'd3);
    send_random(60);
    pause_until_drained();
    send_random(60);

    // Final stretch without idling
    program_hold(16'd2);
    stalls_on = 0;
    send_random(110);

    pause_until_drained();
    repeat (8) @(posedge clk);
    $display("run: %0d requests, %0d result beats (%0d bytes), %0d updates, %0d retries",
             sb.n_requests, sb.n_beats, sb.n_bytes, sb.n_updates, sb.n_retries);
    $display("hold settings 1, 0, 40 (%0d-tick run), 3, 2; %0d mismatches",
             hold_run_ticks, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("led_serial_driver_update_sequencer: match");
    end else begin
      $display("led_serial_driver_update_sequencer: mismatch");
    end
    $finish;
  end

endmodule
